// ----- src/tmlm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tmlm_pkg;

  localparam int PAGE_BITS    = 40;
  localparam int LATENCY_BITS = 16;
  localparam int SUM_BITS     = 48;
  localparam int COUNT_BITS   = 32;
  localparam int SHIFT_BITS   = 3;
  localparam int CFG_ADDR_BITS = 8;
  localparam int CFG_DATA_BITS = 40;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // input op codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_REMOTE_START   = 8'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_LOCAL      = 8'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_REMOTE     = 8'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SMOOTHING_SHIFT = 8'd3;

  localparam logic [PAGE_BITS-1:0]    RESET_REMOTE_START   = 40'd1048576;
  localparam logic [LATENCY_BITS-1:0] RESET_MIN_LOCAL      = 16'd300;
  localparam logic [LATENCY_BITS-1:0] RESET_MIN_REMOTE     = 16'd400;
  localparam logic [SHIFT_BITS-1:0]   RESET_SMOOTHING_SHIFT = 3'd1;

  typedef struct packed {
    logic                    op;
    logic [PAGE_BITS-1:0]    page_number;
    logic [LATENCY_BITS-1:0] latency;
  } in_item_t;

  typedef struct packed {
    logic [LATENCY_BITS-1:0] smoothed_local;
    logic [LATENCY_BITS-1:0] smoothed_remote;
    logic                    local_slower;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_LOCAL  = 2'd0,
    KIND_REMOTE = 2'd1,
    KIND_TICK   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [LATENCY_BITS-1:0] latency;
  } q_entry_t;

  typedef struct packed {
    logic                  start;
    logic [SUM_BITS-1:0]   dividend;
    logic [COUNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [LATENCY_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- src/tmlm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tmlm_front (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire tmlm_pkg::in_item_t            in_data,
  input  wire logic [tmlm_pkg::PAGE_BITS-1:0] remote_start_page,
  input  wire logic                          queue_full,
  output logic                               push,
  output tmlm_pkg::q_entry_t                 push_entry
);
  import tmlm_pkg::*;

  logic accept;

  assign in_ready = ~queue_full;
  assign accept   = in_valid & in_ready;

  always_comb begin
    push_entry.latency = in_data.latency;
    push_entry.kind    = KIND_TICK;
    push               = 1'b0;
    if (in_data.op == OP_TICK) begin
      push = accept;
    end else if (in_data.page_number != '0) begin
      // page zero samples are taken and dropped here
      push            = accept;
      push_entry.kind = (in_data.page_number < remote_start_page) ? KIND_LOCAL : KIND_REMOTE;
    end
  end

endmodule

`default_nettype wire

// ----- src/tmlm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tmlm_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire tmlm_pkg::q_entry_t push_entry,
  input  wire logic               pop,
  output tmlm_pkg::q_entry_t      head,
  output logic                    not_empty,
  output logic                    full
);
  import tmlm_pkg::*;

  q_entry_t               mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   count;
  logic                   do_push;
  logic                   do_pop;

  assign not_empty = (count != '0);
  assign full      = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign head      = mem[rd_ptr];
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/tmlm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is clamped to
// the latency range, so only LATENCY_BITS steps are ever needed.
module tmlm_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tmlm_pkg::div_req_t req,
  output tmlm_pkg::div_rsp_t      rsp
);
  import tmlm_pkg::*;

  localparam int STEP_BITS = $clog2(LATENCY_BITS + 1);

  logic                    busy;
  logic [STEP_BITS-1:0]    steps;
  logic [COUNT_BITS-1:0]   rem;
  logic [COUNT_BITS-1:0]   divisor;
  logic [LATENCY_BITS-1:0] low;
  logic [LATENCY_BITS-1:0] quo;
  logic                    done;
  logic [COUNT_BITS:0]     trial;
  logic                    fits;

  assign trial    = {rem, low[LATENCY_BITS-1]};
  assign fits     = (trial >= {1'b0, divisor});
  assign rsp.done = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= req.dividend[SUM_BITS-1:LATENCY_BITS];
      low     <= req.dividend[LATENCY_BITS-1:0];
      if (req.divisor == '0) begin
        quo <= '0;
      end else if (req.dividend >= {req.divisor, {LATENCY_BITS{1'b0}}}) begin
        quo <= '1;
      end
    end else if (busy) begin
      low <= {low[LATENCY_BITS-2:0], 1'b0};
      quo <= {quo[LATENCY_BITS-2:0], fits};
      rem <= fits ? COUNT_BITS'(trial - {1'b0, divisor}) : trial[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.divisor == '0 ||
            req.dividend >= {req.divisor, {LATENCY_BITS{1'b0}}}) begin
          done <= 1'b1;
        end else begin
          busy  <= 1'b1;
          steps <= STEP_BITS'(LATENCY_BITS);
        end
      end else if (busy) begin
        steps <= steps - STEP_BITS'(1);
        if (steps == STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/tmlm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tmlm_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire tmlm_pkg::q_entry_t                head,
  input  wire logic                              queue_valid,
  output logic                                   pop,
  input  wire logic [tmlm_pkg::LATENCY_BITS-1:0] min_local_latency,
  input  wire logic [tmlm_pkg::LATENCY_BITS-1:0] min_remote_latency,
  input  wire logic [tmlm_pkg::SHIFT_BITS-1:0]   smoothing_shift,
  output tmlm_pkg::div_req_t                     div_req,
  input  wire tmlm_pkg::div_rsp_t                div_rsp,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output tmlm_pkg::out_item_t                    out_data
);
  import tmlm_pkg::*;

  localparam int ACC_BITS = LATENCY_BITS + 2**SHIFT_BITS;

  typedef enum logic [3:0] {
    ST_RUN  = 4'b0001,
    ST_DIVL = 4'b0010,
    ST_DIVR = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t                  state;
  state_t                  state_next;
  logic [SUM_BITS-1:0]     local_sum;
  logic [SUM_BITS-1:0]     remote_sum;
  logic [COUNT_BITS-1:0]   local_count;
  logic [COUNT_BITS-1:0]   remote_count;
  logic [LATENCY_BITS-1:0] local_average;
  logic [LATENCY_BITS-1:0] remote_average;
  logic                    load_out;

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] sum,
                                                  input logic [LATENCY_BITS-1:0] lat);
    logic [SUM_BITS:0] total;
    total = {1'b0, sum} + (SUM_BITS + 1)'(lat);
    return total[SUM_BITS] ? '1 : total[SUM_BITS-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] cnt);
    return (cnt == '1) ? cnt : cnt + COUNT_BITS'(1);
  endfunction

  // s = (avg + (2^k - 1) * s) >> k, with the floor applied to avg first
  function automatic logic [LATENCY_BITS-1:0] ewma(input logic [LATENCY_BITS-1:0] quo,
                                                   input logic [LATENCY_BITS-1:0] floor_val,
                                                   input logic [LATENCY_BITS-1:0] prev,
                                                   input logic [SHIFT_BITS-1:0] k);
    logic [LATENCY_BITS-1:0] avg;
    logic [ACC_BITS-1:0]     acc;
    logic [ACC_BITS-1:0]     shifted;
    avg     = (quo < floor_val) ? floor_val : quo;
    acc     = (ACC_BITS'(prev) << k) - ACC_BITS'(prev) + ACC_BITS'(avg);
    shifted = acc >> k;
    return shifted[LATENCY_BITS-1:0];
  endfunction

  assign load_out = (state == ST_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    div_req    = '0;
    case (state)
      ST_RUN: begin
        if (queue_valid) begin
          pop = 1'b1;
          if (head.kind == KIND_TICK) begin
            div_req.start    = 1'b1;
            div_req.dividend = local_sum;
            div_req.divisor  = local_count;
            state_next       = ST_DIVL;
          end
        end
      end
      ST_DIVL: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = remote_sum;
          div_req.divisor  = remote_count;
          state_next       = ST_DIVR;
        end
      end
      ST_DIVR: begin
        if (div_rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.smoothed_local  <= local_average;
      out_data.smoothed_remote <= remote_average;
      out_data.local_slower    <= (local_average > remote_average);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_RUN;
      local_sum      <= '0;
      remote_sum     <= '0;
      local_count    <= '0;
      remote_count   <= '0;
      local_average  <= '0;
      remote_average <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RUN && queue_valid) begin
        case (head.kind)
          KIND_LOCAL: begin
            local_sum   <= sat_add(local_sum, head.latency);
            local_count <= sat_inc(local_count);
          end
          KIND_REMOTE: begin
            remote_sum   <= sat_add(remote_sum, head.latency);
            remote_count <= sat_inc(remote_count);
          end
          default: ;
        endcase
      end
      if (state == ST_DIVL && div_rsp.done) begin
        local_average <= ewma(div_rsp.quotient, min_local_latency, local_average,
                              smoothing_shift);
      end
      if (state == ST_DIVR && div_rsp.done) begin
        remote_average <= ewma(div_rsp.quotient, min_remote_latency, remote_average,
                               smoothing_shift);
      end
      if (load_out) begin
        out_valid    <= 1'b1;
        local_sum    <= '0;
        remote_sum   <= '0;
        local_count  <= '0;
        remote_count <= '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/tiered_memory_latency_monitor.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Samples: one transaction per cycle while in_ready is high; each is accumulated at the edge
// it leaves the queue. Tick: the result is set by the shared divider, which runs local then
// remote (one quotient bit a cycle) before the result register loads; input stalls meanwhile
// once the 2-entry queue fills. The result register holds one pending result.
// Reset (rst, synchronous): sums, counts and smoothed values clear, config takes reset values.
module tiered_memory_latency_monitor (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire tmlm_pkg::in_item_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output tmlm_pkg::out_item_t                     out_data,
  input  wire logic                               cfg_wr_en,
  input  wire logic [tmlm_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [tmlm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import tmlm_pkg::*;

  logic [PAGE_BITS-1:0]    remote_start_page;
  logic [LATENCY_BITS-1:0] min_local_latency;
  logic [LATENCY_BITS-1:0] min_remote_latency;
  logic [SHIFT_BITS-1:0]   smoothing_shift;

  logic     push;
  q_entry_t push_entry;
  logic     pop;
  q_entry_t head;
  logic     queue_valid;
  logic     queue_full;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      remote_start_page  <= RESET_REMOTE_START;
      min_local_latency  <= RESET_MIN_LOCAL;
      min_remote_latency <= RESET_MIN_REMOTE;
      smoothing_shift    <= RESET_SMOOTHING_SHIFT;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_REMOTE_START:    remote_start_page  <= cfg_data[PAGE_BITS-1:0];
        REG_MIN_LOCAL:       min_local_latency  <= cfg_data[LATENCY_BITS-1:0];
        REG_MIN_REMOTE:      min_remote_latency <= cfg_data[LATENCY_BITS-1:0];
        REG_SMOOTHING_SHIFT: smoothing_shift    <= cfg_data[SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  tmlm_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .remote_start_page (remote_start_page),
    .queue_full        (queue_full),
    .push              (push),
    .push_entry        (push_entry)
  );

  tmlm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (queue_valid),
    .full       (queue_full)
  );

  tmlm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tmlm_back u_back (
    .clk                (clk),
    .rst                (rst),
    .head               (head),
    .queue_valid        (queue_valid),
    .pop                (pop),
    .min_local_latency  (min_local_latency),
    .min_remote_latency (min_remote_latency),
    .smoothing_shift    (smoothing_shift),
    .div_req            (div_req),
    .div_rsp            (div_rsp),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data           (out_data)
  );

endmodule

`default_nettype wire
